// ===== design/hge_pkg.sv =====
`timescale 1ns / 1ps

package hge_pkg;

	localparam int UNIT_W = 16;
	localparam int NIB_W  = 4;
	localparam int IDX_W  = 3;

	// position of each unit within an escape sequence
	localparam logic [IDX_W-1:0] IDX_PLUS  = 3'd0;
	localparam logic [IDX_W-1:0] IDX_TAG   = 3'd1;
	localparam logic [IDX_W-1:0] IDX_HEX3  = 3'd2;
	localparam logic [IDX_W-1:0] IDX_HEX2  = 3'd3;
	localparam logic [IDX_W-1:0] IDX_HEX1  = 3'd4;
	localparam logic [IDX_W-1:0] IDX_HEX0  = 3'd5;

	localparam logic [UNIT_W-1:0] CH_PLUS  = 16'h002B;
	localparam logic [UNIT_W-1:0] CH_LOWX  = 16'h0078;
	localparam logic [UNIT_W-1:0] CH_UPX   = 16'h0058;
	localparam logic [UNIT_W-1:0] CH_AT    = 16'h0040;
	localparam logic [UNIT_W-1:0] CH_ZERO  = 16'h0030;
	localparam logic [UNIT_W-1:0] CH_ALPHA = 16'h0037; // 'A' - 10

	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_HANGUL,
		KIND_SYMBOL
	} kind_t;

	typedef struct packed {
		logic [UNIT_W-1:0] code;
		kind_t             kind;
	} item_t;

	typedef struct packed {
		logic [UNIT_W-1:0] lo;
		logic [UNIT_W-1:0] hi;
	} span_t;

	localparam int NUM_SPANS = 74;

	localparam span_t SYM_SPANS [NUM_SPANS] = '{
		'{16'h00A1, 16'h00A1}, '{16'h00BC, 16'h00BF}, '{16'h0111, 16'h0111},
		'{16'h0126, 16'h0127}, '{16'h0131, 16'h0133}, '{16'h0138, 16'h0138},
		'{16'h013F, 16'h0142}, '{16'h0149, 16'h014B}, '{16'h0152, 16'h0153},
		'{16'h0166, 16'h0167}, '{16'h02C7, 16'h02C7}, '{16'h02D0, 16'h02D0},
		'{16'h02D8, 16'h02DB}, '{16'h02DD, 16'h02DD}, '{16'h207F, 16'h207F},
		'{16'h2081, 16'h2084}, '{16'h20AC, 16'h20AC}, '{16'h2109, 16'h2109},
		'{16'h2113, 16'h2113}, '{16'h2122, 16'h2122}, '{16'h2126, 16'h2126},
		'{16'h2153, 16'h2154}, '{16'h215B, 16'h215E}, '{16'h2170, 16'h2179},
		'{16'h2194, 16'h2199}, '{16'h220F, 16'h220F}, '{16'h223C, 16'h223C},
		'{16'h2299, 16'h2299}, '{16'h2460, 16'h246E}, '{16'h2474, 16'h2482},
		'{16'h249C, 16'h24B5}, '{16'h24D0, 16'h24E9}, '{16'h250D, 16'h250E},
		'{16'h2511, 16'h2512}, '{16'h2515, 16'h2516}, '{16'h2519, 16'h251A},
		'{16'h251E, 16'h251F}, '{16'h2521, 16'h2522}, '{16'h2526, 16'h2527},
		'{16'h252A, 16'h252A}, '{16'h252D, 16'h252E}, '{16'h2531, 16'h2532},
		'{16'h2535, 16'h2536}, '{16'h2539, 16'h253A}, '{16'h253D, 16'h253E},
		'{16'h2540, 16'h2541}, '{16'h2543, 16'h254A}, '{16'h2592, 16'h2592},
		'{16'h25A3, 16'h25A9}, '{16'h25B6, 16'h25B7}, '{16'h25C0, 16'h25C1},
		'{16'h25C8, 16'h25C8}, '{16'h25D0, 16'h25D1}, '{16'h260E, 16'h260F},
		'{16'h261C, 16'h261C}, '{16'h261E, 16'h261E}, '{16'h2660, 16'h2661},
		'{16'h2663, 16'h2665}, '{16'h2667, 16'h2669}, '{16'h266C, 16'h266C},
		'{16'h3200, 16'h321C}, '{16'h3260, 16'h327B}, '{16'h327F, 16'h327F},
		'{16'h3380, 16'h3384}, '{16'h3388, 16'h338D}, '{16'h3390, 16'h339B},
		'{16'h339F, 16'h33A0}, '{16'h33A2, 16'h33B8}, '{16'h33BA, 16'h33C3},
		'{16'h33C5, 16'h33CA}, '{16'h33CF, 16'h33D0}, '{16'h33D3, 16'h33D3},
		'{16'h33D6, 16'h33D6}, '{16'h33D8, 16'h33D8}
	};

	// spans that did not fit the table above
	localparam logic [UNIT_W-1:0] SYM_EXTRA0 = 16'h33DB;
	localparam logic [UNIT_W-1:0] SYM_EXTRA1 = 16'h33DD;
	localparam logic [UNIT_W-1:0] SYM_EXTRA2 = 16'hFF02;
	localparam logic [UNIT_W-1:0] SYM_EXTRA3 = 16'hFF07;
	localparam logic [UNIT_W-1:0] SYM_EXTRA4 = 16'hFFE6;

	function automatic logic is_hangul(input logic [UNIT_W-1:0] u);
		return (u == CH_AT) || (u == '0) ||
			(u >= 16'h1100 && u <= 16'h11FF) ||
			(u >= 16'h3130 && u <= 16'h318F) ||
			(u >= 16'hA960 && u <= 16'hA97F) ||
			(u >= 16'hAC00 && u <= 16'hD7FF);
	endfunction

	function automatic logic is_symbol(input logic [UNIT_W-1:0] u);
		logic hit;
		hit = (u >= SYM_EXTRA0 && u <= SYM_EXTRA1) || (u == SYM_EXTRA2) ||
			(u == SYM_EXTRA3) || (u == SYM_EXTRA4);
		for (int i = 0; i < NUM_SPANS; i++) begin
			hit = hit | ((u >= SYM_SPANS[i].lo) && (u <= SYM_SPANS[i].hi));
		end
		return hit;
	endfunction

	function automatic logic [UNIT_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
		logic [UNIT_W-1:0] n;
		n = {{(UNIT_W-NIB_W){1'b0}}, nib};
		return (nib < 4'd10) ? (CH_ZERO + n) : (CH_ALPHA + n);
	endfunction

endpackage

// ===== design/hge_if.sv =====
`timescale 1ns / 1ps

interface hge_in_if;
	logic                           valid;
	logic                           ready;
	logic [hge_pkg::UNIT_W-1:0]     code_unit;

	modport source (output valid, output code_unit, input ready);
	modport sink (input valid, input code_unit, output ready);
endinterface

interface hge_out_if;
	logic                           valid;
	logic                           ready;
	logic [hge_pkg::UNIT_W-1:0]     out_unit;
	logic                           run_last;

	modport source (output valid, output out_unit, output run_last, input ready);
	modport sink (input valid, input out_unit, input run_last, output ready);
endinterface

// ===== design/hge_classify.sv =====
`timescale 1ns / 1ps

module hge_classify (
	input  logic            clk,
	input  logic            arst_n,
	hge_in_if.sink          din,
	output hge_pkg::item_t  item,
	output logic            item_valid,
	input  logic            item_take
);

	logic                       valid_s1;
	logic [hge_pkg::UNIT_W-1:0] code_s1;
	logic                       load;

	assign din.ready = !valid_s1 || item_take;
	assign load      = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_s1 <= din.code_unit;
		end
	end

	// Hangul set wins over the symbol table
	always_comb begin
		item.code = code_s1;
		if (hge_pkg::is_hangul(code_s1)) begin
			item.kind = hge_pkg::KIND_HANGUL;
		end else if (hge_pkg::is_symbol(code_s1)) begin
			item.kind = hge_pkg::KIND_SYMBOL;
		end else begin
			item.kind = hge_pkg::KIND_PASS;
		end
	end

	assign item_valid = valid_s1;

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> din.ready) else $error("input stage empty but not ready");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !item_take) |=> (valid_s1 && $stable(code_s1)))
		else $error("stalled input stage lost its unit");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (valid_s1 && code_s1 == $past(din.code_unit)))
		else $error("accepted unit not captured");

endmodule

// ===== design/hge_emit.sv =====
`timescale 1ns / 1ps

module hge_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  hge_pkg::item_t  item,
	input  logic            item_valid,
	output logic            item_take,
	hge_out_if.source       dout
);

	logic                       valid_s2;
	logic [hge_pkg::UNIT_W-1:0] code_s2;
	hge_pkg::kind_t             kind_s2;
	logic [hge_pkg::IDX_W-1:0]  idx_q;
	logic                       last;
	logic                       xfer;
	logic                       load;

	assign last      = (kind_s2 == hge_pkg::KIND_PASS) || (idx_q == hge_pkg::IDX_HEX0);
	assign xfer      = valid_s2 && dout.ready;
	assign item_take = !valid_s2 || (dout.ready && last);
	assign load      = item_valid && item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= hge_pkg::IDX_PLUS;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= hge_pkg::IDX_PLUS;
		end else if (xfer) begin
			// advance through the escape sequence, drop the item after its last unit
			if (last) begin
				valid_s2 <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_s2 <= item.code;
			kind_s2 <= item.kind;
		end
	end

	always_comb begin
		dout.out_unit = code_s2;
		if (kind_s2 != hge_pkg::KIND_PASS) begin
			unique case (idx_q)
				hge_pkg::IDX_PLUS: dout.out_unit = hge_pkg::CH_PLUS;
				hge_pkg::IDX_TAG:  dout.out_unit = (kind_s2 == hge_pkg::KIND_HANGUL) ?
					hge_pkg::CH_LOWX : hge_pkg::CH_UPX;
				hge_pkg::IDX_HEX3: dout.out_unit = hge_pkg::hex_char(code_s2[15:12]);
				hge_pkg::IDX_HEX2: dout.out_unit = hge_pkg::hex_char(code_s2[11:8]);
				hge_pkg::IDX_HEX1: dout.out_unit = hge_pkg::hex_char(code_s2[7:4]);
				hge_pkg::IDX_HEX0: dout.out_unit = hge_pkg::hex_char(code_s2[3:0]);
				default:           dout.out_unit = code_s2;
			endcase
		end
	end

	assign dout.valid    = valid_s2;
	assign dout.run_last = last;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q <= hge_pkg::IDX_HEX0)) else $error("escape index out of range");

	a_pass_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 == hge_pkg::KIND_PASS) |-> (idx_q == hge_pkg::IDX_PLUS && last))
		else $error("pass-through unit not a single transfer");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !last) |=> (valid_s2 && idx_q == $past(idx_q) + 3'd1 && $stable(code_s2)))
		else $error("escape sequence did not advance by one");

endmodule

// ===== design/hangul_escape_encoder_top.sv =====
`timescale 1ns / 1ps

// Escapes a stream of 16-bit text units. '@', zero and Hangul units come out as the six
// units "+x" and four uppercase hex digits, units of the fixed symbol table as "+X" and
// four hex digits, and every other unit as itself; run_last marks the final unit of each
// input. An input register feeds the classifier and an output stage walks the escape
// sequence, so the first result of a unit is offered once it has left the input register,
// a pass-through unit occupies the output stage for one transfer, and the next unit is
// taken in the same cycle the previous result transfers; an escaped unit occupies the
// output stage for six transfers, while one further unit is held in the input register.
module hangul_escape_encoder_top (
	input  logic      clk,
	input  logic      arst_n,
	hge_in_if.sink    din,
	hge_out_if.source dout
);

	hge_pkg::item_t item;
	logic           item_valid;
	logic           item_take;

	hge_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take)
	);

	hge_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.dout       (dout)
	);

endmodule
